### rtl/button_click_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared assertion forms for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcc checker: next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcc checker: same-cycle property failed");

`endif

### rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Button click classifier package
// Types, event codes and register indexes shared by the classifier files.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int ELAPSED_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd280;
  localparam logic [CFG_W-1:0] HOLD_RST       = 16'd10000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_HOLD   = 2'd2,
    EV_DOUBLE = 2'd3
  } ev_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_DOUBLE_GAP = 2'd1,
    CFG_HOLD       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_gap_ms;
    logic [CFG_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                 button_level;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } sample_t;

endpackage

### rtl/bcc_in_if.sv
// ----------------------------------------------------------------------------
// Poll input channel
// Valid/ready channel carrying one button poll per word.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic       valid;
  logic       ready;
  logic       button_level;
  logic [7:0] elapsed_ms;

  modport source (output valid, output button_level, output elapsed_ms, input ready);
  modport sink   (input valid, input button_level, input elapsed_ms, output ready);
endinterface

### rtl/bcc_out_if.sv
// ----------------------------------------------------------------------------
// Event output channel
// Valid/ready channel carrying one event code per word.
// ----------------------------------------------------------------------------
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

### rtl/bcc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Debounce, double-click gap and hold time, written through the cfg channel.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  bcc_cfg_if.sink       cfg_ch,
  output cfg_t          cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.double_gap_ms <= DOUBLE_GAP_RST;
      cfg_r.hold_ms       <= HOLD_RST;
    end else if (cfg_ch.valid) begin
      // Writes to an index beyond the register list are dropped.
      unique case (cfg_ch.index)
        CFG_DEBOUNCE:   cfg_r.debounce_ms   <= cfg_ch.data;
        CFG_DOUBLE_GAP: cfg_r.double_gap_ms <= cfg_ch.data;
        CFG_HOLD:       cfg_r.hold_ms       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/bcc_in_stage.sv
// ----------------------------------------------------------------------------
// Poll input register
// Captures each accepted poll word and hands it to the classifier.
// ----------------------------------------------------------------------------
module bcc_in_stage
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  bcc_in_if.sink  in_ch,
  output logic    smp_valid,
  input  logic    smp_ready,
  output sample_t smp
);

  logic    valid_r;
  sample_t smp_r;
  logic    take;

  assign in_ch.ready = !valid_r || smp_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign smp_valid   = valid_r;
  assign smp         = smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (smp_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp_r.button_level <= in_ch.button_level;
      smp_r.elapsed_ms   <= in_ch.elapsed_ms;
    end
  end

endmodule

### rtl/bcc_classify.sv
// ----------------------------------------------------------------------------
// Click classifier
// Holds the running time and click flags, classifies one poll per cycle while
// the event register is free or read, and registers the resulting event code.
// ----------------------------------------------------------------------------
module bcc_classify
  import bcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       smp_valid,
  output logic       smp_ready,
  input  sample_t    smp,
  bcc_out_if.source  out_ch
);

  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] press_r, press_nxt;
  logic [TIME_W-1:0] release_r, release_nxt;
  logic              last_level_r, last_level_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic              marked_r, marked_nxt;
  logic              single_ok_r, single_ok_nxt;
  logic              skip_rel_r, skip_rel_nxt;
  logic              hold_rep_r, hold_rep_nxt;
  ev_code_t          ev_nxt;
  ev_code_t          code_r;
  logic              out_valid_r;
  logic              adv;

  logic [TIME_W-1:0] deb_ext, gap_ext, hold_ext;

  assign smp_ready       = !out_valid_r || out_ch.ready;
  assign adv             = smp_valid && smp_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.event_code = code_r;

  assign deb_ext  = {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
  assign gap_ext  = {{(TIME_W-CFG_W){1'b0}}, cfg.double_gap_ms};
  assign hold_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms};

  always_comb begin
    logic [TIME_W-1:0] since_up;
    logic [TIME_W-1:0] since_down;
    logic              lvl;
    logic              rel_taken;

    lvl       = smp.button_level;
    now_nxt   = now_r + {{(TIME_W-ELAPSED_W){1'b0}}, smp.elapsed_ms};
    since_up  = now_nxt - release_r;
    since_down = now_nxt - press_r;

    press_nxt      = press_r;
    release_nxt    = release_r;
    awaiting_nxt   = awaiting_r;
    marked_nxt     = marked_r;
    single_ok_nxt  = single_ok_r;
    skip_rel_nxt   = skip_rel_r;
    hold_rep_nxt   = hold_rep_r;
    last_level_nxt = lvl;
    ev_nxt         = EV_NONE;
    rel_taken      = 1'b0;

    if (!lvl && last_level_r && (since_up > deb_ext)) begin
      press_nxt     = now_nxt;
      skip_rel_nxt  = 1'b0;
      single_ok_nxt = 1'b1;
      hold_rep_nxt  = 1'b0;
      marked_nxt    = (since_up < gap_ext) && !marked_r && awaiting_r;
      awaiting_nxt  = 1'b0;
    end else if (lvl && !last_level_r && (since_down > deb_ext) && !skip_rel_r) begin
      // The release right after a reported hold is swallowed.
      release_nxt = now_nxt;
      rel_taken   = 1'b1;
      if (!marked_r) begin
        awaiting_nxt = 1'b1;
      end else begin
        ev_nxt        = EV_DOUBLE;
        marked_nxt    = 1'b0;
        awaiting_nxt  = 1'b0;
        single_ok_nxt = 1'b0;
      end
    end

    // A timestamp just taken restarts its interval at zero.
    if (rel_taken) begin
      since_up = '0;
    end
    if (press_nxt != press_r || (!lvl && last_level_r && (now_nxt - release_r) > deb_ext)) begin
      since_down = '0;
    end

    if (lvl && (since_up >= gap_ext) && awaiting_nxt && !marked_nxt && single_ok_nxt &&
        (ev_nxt != EV_DOUBLE)) begin
      ev_nxt       = EV_SINGLE;
      awaiting_nxt = 1'b0;
    end

    if (!lvl && (since_down >= hold_ext) && !hold_rep_nxt) begin
      ev_nxt       = EV_HOLD;
      skip_rel_nxt = 1'b1;
      marked_nxt   = 1'b0;
      awaiting_nxt = 1'b0;
      hold_rep_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      press_r      <= '1;
      release_r    <= '1;
      last_level_r <= 1'b1;
      awaiting_r   <= 1'b0;
      marked_r     <= 1'b0;
      single_ok_r  <= 1'b1;
      skip_rel_r   <= 1'b0;
      hold_rep_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      now_r        <= now_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
      last_level_r <= last_level_nxt;
      awaiting_r   <= awaiting_nxt;
      marked_r     <= marked_nxt;
      single_ok_r  <= single_ok_nxt;
      skip_rel_r   <= skip_rel_nxt;
      hold_rep_r   <= hold_rep_nxt;
      out_valid_r  <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= ev_nxt;
    end
  end

endmodule

### rtl/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// Button click classifier
// Classifies polls of an active-low button into click, double click and hold.
// ----------------------------------------------------------------------------
// Each poll word (level plus milliseconds since the previous poll) yields
// exactly one event word: none, single click, hold or double click. The block
// takes one poll word per cycle unless back-pressure stalls it, and each
// accepted poll is held in the input register, then takes one pass through
// the 32-bit time add, interval subtract and compare into the event register.
// Back-pressure on the event channel stalls the poll channel only once both
// registers are full. Configuration words are taken at any time and should
// be written while no poll is in flight. There is no clearing pass after
// reset.
module button_click_classifier_top
  import bcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bcc_in_if.sink     in_ch,
  bcc_out_if.source  out_ch,
  bcc_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  logic    smp_ready;

  bcc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bcc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp       (smp)
  );

  bcc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp       (smp),
    .out_ch    (out_ch)
  );

endmodule

### rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// Button click classifier checker
// Watches the event channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "button_click_classifier_top_macros.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_code
);

  logic [1:0] last_code_r;
  logic       out_take;

  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_code_r <= EV_NONE;
    end else if (out_take) begin
      last_code_r <= out_code;
    end
  end

  `BCC_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid)
  `BCC_ASSERT_NEXT(a_code_holds, out_valid && !out_ready, $stable(out_code))
  // A new hold needs a fresh press, which needs a high poll in between.
  `BCC_ASSERT_SAME(a_no_hold_twice, out_take && (last_code_r == EV_HOLD), out_code != EV_HOLD)
  // Two release edges cannot come from consecutive polls.
  `BCC_ASSERT_SAME(a_no_double_twice, out_take && (last_code_r == EV_DOUBLE),
                   out_code != EV_DOUBLE)

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_code  (out_ch.event_code)
);

### bench/bcc_click_checker.sv
// ----------------------------------------------------------------------------
// Button click classifier event checker
// Watches the poll, event and configuration channels, predicts the event
// code for every accepted poll and compares it with the event words that
// the classifier hands out, in order.
// ----------------------------------------------------------------------------
module bcc_click_checker
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bcc_in_if           poll_mon,
  bcc_out_if          event_mon,
  bcc_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned singles_seen,
  output int unsigned doubles_seen,
  output int unsigned holds_seen
);

  // Register copies.
  logic [CFG_W-1:0] debounce_win;
  logic [CFG_W-1:0] gap_win;
  logic [CFG_W-1:0] hold_win;

  // Classifier state as the predictor sees it.
  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] down_stamp;
  logic [TIME_W-1:0] up_stamp;
  logic              prev_level;
  logic              waiting_second;
  logic              second_armed;
  logic              single_ok;
  logic              ignore_release;
  logic              hold_seen;

  ev_code_t    expected_events[$];
  int unsigned events_checked;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) begin
      $display("click_chk: event word %0d: %s", events_checked, what);
    end
  endtask

  // Advances the predicted state by one poll and returns the event it yields.
  function automatic ev_code_t classify_poll(input logic level, input logic [7:0] ms);
    logic [TIME_W-1:0] up_for;
    logic [TIME_W-1:0] down_for;
    ev_code_t          ev;
    ev       = EV_NONE;
    clock_ms = clock_ms + {24'd0, ms};
    up_for   = clock_ms - up_stamp;
    down_for = clock_ms - down_stamp;

    if (!level && prev_level && up_for > {16'd0, debounce_win}) begin
      down_stamp     = clock_ms;
      ignore_release = 1'b0;
      single_ok      = 1'b1;
      hold_seen      = 1'b0;
      second_armed   = (up_for < {16'd0, gap_win}) && !second_armed && waiting_second;
      waiting_second = 1'b0;
    end else if (level && !prev_level && down_for > {16'd0, debounce_win}) begin
      // The release that ends a reported hold leaves the timestamps and click flags alone.
      if (!ignore_release) begin
        up_stamp = clock_ms;
        if (!second_armed) begin
          waiting_second = 1'b1;
        end else begin
          ev             = EV_DOUBLE;
          second_armed   = 1'b0;
          waiting_second = 1'b0;
          single_ok      = 1'b0;
        end
      end
    end

    up_for   = clock_ms - up_stamp;
    down_for = clock_ms - down_stamp;

    if (level && up_for >= {16'd0, gap_win} && waiting_second && !second_armed &&
        single_ok && ev != EV_DOUBLE) begin
      ev             = EV_SINGLE;
      waiting_second = 1'b0;
    end

    // A low level is timed even when no press was ever accepted.
    if (!level && down_for >= {16'd0, hold_win} && !hold_seen) begin
      ev             = EV_HOLD;
      ignore_release = 1'b1;
      second_armed   = 1'b0;
      waiting_second = 1'b0;
      hold_seen      = 1'b1;
    end

    prev_level = level;
    return ev;
  endfunction

  always @(posedge clk) begin
    ev_code_t want;
    if (!rst_n) begin
      debounce_win   = DEBOUNCE_RST;
      gap_win        = DOUBLE_GAP_RST;
      hold_win       = HOLD_RST;
      clock_ms       = '0;
      down_stamp     = '1;
      up_stamp       = '1;
      prev_level     = 1'b1;
      waiting_second = 1'b0;
      second_armed   = 1'b0;
      single_ok      = 1'b1;
      ignore_release = 1'b0;
      hold_seen      = 1'b0;
      expected_events.delete();
      pending        = 0;
      mismatches     = 0;
      events_checked = 0;
      singles_seen   = 0;
      doubles_seen   = 0;
      holds_seen     = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DEBOUNCE:   debounce_win = cfg_mon.data;
          CFG_DOUBLE_GAP: gap_win      = cfg_mon.data;
          CFG_HOLD:       hold_win     = cfg_mon.data;
          default: ;
        endcase
      end

      if (event_mon.valid && event_mon.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("code %0d arrived with no poll waiting",
                                    event_mon.event_code));
        end else begin
          want = expected_events.pop_front();
          if (event_mon.event_code !== want) begin
            report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                      event_mon.event_code, want, want.name()));
          end
          case (want)
            EV_SINGLE: singles_seen++;
            EV_DOUBLE: doubles_seen++;
            EV_HOLD:   holds_seen++;
            default: ;
          endcase
        end
        events_checked++;
      end

      if (poll_mon.valid && poll_mon.ready) begin
        expected_events.push_back(classify_poll(poll_mon.button_level,
                                                poll_mon.elapsed_ms));
      end
      pending = expected_events.size();
    end
  end

endmodule

### bench/tb_button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Feeds button polls shaped as clicks, double clicks, holds and bounce under
// several register settings, with random gaps and back-pressure, and lets the
// event checker compare every event word against its own prediction.
// ----------------------------------------------------------------------------
module tb_button_click_classifier_top;
  import bcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned POLL_TARGET    = 850;
  localparam int unsigned PHASE_POLLS    = 110;
  localparam logic [1:0]  CFG_SPARE_IDX  = 2'd3;
  localparam int unsigned HOLDOFF_AT     = 300;
  localparam int unsigned HOLDOFF_CYCLES = 200;

  logic clk;
  logic rst_n;

  bcc_in_if  in_ch ();
  bcc_out_if out_ch ();
  bcc_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned singles_seen;
  int unsigned doubles_seen;
  int unsigned holds_seen;

  int unsigned polls_sent;
  int unsigned settings_used;
  int unsigned cycle_count;
  int          cur_debounce;
  int          cur_gap;
  int          cur_hold;
  logic        no_idle;
  logic        rx_holdoff;

  button_click_classifier_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bcc_click_checker click_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_mon     (in_ch),
    .event_mon    (out_ch),
    .cfg_mon      (cfg_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .singles_seen (singles_seen),
    .doubles_seen (doubles_seen),
    .holds_seen   (holds_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // A stretch in the middle of the run with no idling on either side.
  always @(posedge clk) begin
    no_idle <= (polls_sent >= 500) && (polls_sent < 650);
  end

  // Long receiver hold-off so the block fills up and stalls the poll channel.
  initial begin
    rx_holdoff = 1'b0;
    @(posedge clk);
    while (polls_sent < HOLDOFF_AT) @(posedge clk);
    rx_holdoff = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rx_holdoff = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !rx_holdoff && (no_idle || $urandom_range(0, 99) >= 6);
    end
  end

  task automatic send_poll(input logic level, input logic [7:0] ms);
    while (!no_idle && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_level <= level;
    in_ch.elapsed_ms   <= ms;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    polls_sent++;
  endtask

  task automatic drain_events();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Only called with no poll in flight. The spare index must be ignored.
  task automatic write_settings(input int db, input int gap, input int hold,
                                input bit poke_spare);
    write_reg(CFG_DEBOUNCE, 16'(db));
    write_reg(CFG_DOUBLE_GAP, 16'(gap));
    write_reg(CFG_HOLD, 16'(hold));
    if (poke_spare) write_reg(CFG_SPARE_IDX, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    cur_debounce = db;
    cur_gap      = gap;
    cur_hold     = hold;
    settings_used++;
  endtask

  function automatic int between(input int lo, input int hi);
    if (hi <= lo) return lo;
    return $urandom_range(lo, hi);
  endfunction

  // Keeps the level steady until at least dur ms have been reported.
  task automatic emit_level(input logic level, input int dur);
    int spent;
    int pick;
    int step;
    spent = 0;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 8) step = 0;
      else if (pick < 80) step = $urandom_range(1, 40);
      else step = $urandom_range(41, 255);
      send_poll(level, 8'(step));
      spent += step;
    end while (spent < dur);
  endtask

  task automatic play_gesture();
    int pick;
    int i;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      emit_level(1'b0, between(cur_debounce + 1, cur_hold / 2));
      emit_level(1'b1, between(cur_gap, cur_gap + 300));
    end else if (pick < 60) begin
      emit_level(1'b0, between(cur_debounce + 1, cur_debounce + 150));
      emit_level(1'b1, between(cur_debounce + 1, cur_gap));
      emit_level(1'b0, between(cur_debounce + 1, cur_debounce + 150));
      emit_level(1'b1, between(cur_gap, cur_gap + 300));
    end else if (pick < 80 && cur_hold <= 3000) begin
      emit_level(1'b0, between(cur_hold, cur_hold + 400));
      emit_level(1'b1, between(0, cur_gap + 200));
    end else if (pick < 90) begin
      // Contact bounce: fast alternating levels.
      for (i = 0; i < between(2, 6); i++) begin
        send_poll(i[0], 8'($urandom_range(0, 3)));
      end
    end else begin
      for (i = 0; i < between(1, 5); i++) begin
        send_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic play_phase(input int unsigned count);
    int unsigned start;
    start = polls_sent;
    while (polls_sent - start < count) play_gesture();
  endtask

  initial begin
    cycle_count        = 0;
    polls_sent         = 0;
    settings_used      = 1;
    cur_debounce       = DEBOUNCE_RST;
    cur_gap            = DOUBLE_GAP_RST;
    cur_hold           = HOLD_RST;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b1;
    in_ch.elapsed_ms   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: low at start, rejected edges, a click and a double click.
    send_poll(1'b0, 8'd0);
    send_poll(1'b1, 8'd5);
    send_poll(1'b0, 8'd255);
    send_poll(1'b1, 8'd20);
    send_poll(1'b1, 8'd255);
    send_poll(1'b1, 8'd255);
    send_poll(1'b0, 8'd50);
    send_poll(1'b1, 8'd50);
    send_poll(1'b0, 8'd100);
    send_poll(1'b1, 8'd50);
    send_poll(1'b1, 8'd255);
    send_poll(1'b0, 8'd3);
    play_phase(70);
    drain_events();

    // All zero: a hold on the press itself, then the ignored release.
    write_settings(0, 0, 0, 1'b1);
    send_poll(1'b0, 8'd1);
    send_poll(1'b1, 8'd1);
    send_poll(1'b0, 8'd0);
    send_poll(1'b1, 8'd0);
    send_poll(1'b1, 8'd5);
    send_poll(1'b0, 8'd5);
    send_poll(1'b1, 8'd5);
    send_poll(1'b1, 8'd0);
    play_phase(50);
    drain_events();

    // All max: edges are mostly rejected. Gesture shapes would stretch over
    // thousands of polls here, so random polls are used instead.
    write_settings(65535, 65535, 65535, 1'b0);
    send_poll(1'b0, 8'd255);
    send_poll(1'b1, 8'd255);
    send_poll(1'b0, 8'd0);
    send_poll(1'b1, 8'd128);
    repeat (40) send_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    while (polls_sent < POLL_TARGET) begin
      drain_events();
      write_settings(between(0, 60), between(0, 400), between(100, 2500), 1'b0);
      play_phase(PHASE_POLLS);
    end

    drain_events();
    repeat (4) @(negedge clk);
    $display("tb: %0d polls classified under %0d register settings, zeros and maxima included",
             polls_sent, settings_used);
    $display("tb: events checked: %0d single, %0d double, %0d hold",
             singles_seen, doubles_seen, holds_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bcc_pkg.sv
rtl/bcc_in_if.sv
rtl/bcc_out_if.sv
rtl/bcc_cfg_if.sv
rtl/bcc_cfg_regs.sv
rtl/bcc_in_stage.sv
rtl/bcc_classify.sv
rtl/button_click_classifier_top.sv
rtl/bcc_checker.sv
bench/bcc_click_checker.sv
bench/tb_button_click_classifier_top.sv
